// ===== src/prbs_pkg.sv =====
// ----------------------------------------------------------------------------
// prbs_pkg
// Types and constants shared by the retention buffer sampler modules.
// ----------------------------------------------------------------------------
package prbs_pkg;

  localparam int unsigned PER_MILLE = 1000;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned IDX_W     = 3;

  localparam logic       MODE_RECORD  = 1'b0;
  localparam logic       MODE_EXPORT  = 1'b1;
  localparam logic       KIND_SPAN    = 1'b0;
  localparam logic       KIND_CORRECT = 1'b1;
  localparam logic [1:0] PRIO_VERBOSE = 2'd0;
  localparam logic [1:0] PRIO_NORMAL  = 2'd1;
  localparam logic [1:0] PRIO_TAIL    = 2'd2;
  localparam logic [1:0] PRIO_ERROR   = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_CAPACITY = 3'd0,
    REG_BASE     = 3'd1,
    REG_FLOOR    = 3'd2,
    REG_LOW      = 3'd3,
    REG_HIGH     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_EVICTED    = 3'd1,
    ST_DROP_NC    = 3'd2,
    ST_DROP_CRIT  = 3'd3,
    ST_EXP_ENTRY  = 3'd4,
    ST_EXP_EMPTY  = 3'd5
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  prio;
    logic [63:0] trace;
    logic [63:0] span;
    logic [63:0] time_ns;
    logic [63:0] measure;
  } entry_t;

  typedef struct packed {
    logic   mode;
    logic   critical;
    logic   clear;
    entry_t ent;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    entry_t      ent;
    logic        last;
    logic [9:0]  rate;
    logic [31:0] verbose;
    logic [31:0] normal;
    logic [31:0] critical;
  } result_t;

endpackage

// ===== src/prbs_front.sv =====
// ----------------------------------------------------------------------------
// prbs_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module prbs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            mode,
  input  logic            event_kind,
  input  logic [1:0]      event_priority,
  input  logic [63:0]     trace_ident,
  input  logic [63:0]     span_ident,
  input  logic [63:0]     time_ns,
  input  logic [63:0]     measure,
  input  logic            clear_after,
  output logic            cmd_valid,
  input  logic            cmd_pop,
  output prbs_pkg::cmd_t  cmd
);
  import prbs_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       c_in;
  logic       do_push, do_pop;

  always_comb begin
    c_in.mode        = mode;
    c_in.clear       = clear_after;
    c_in.ent.kind    = event_kind;
    c_in.ent.prio    = (event_kind == KIND_CORRECT) ? PRIO_ERROR : event_priority;
    c_in.critical    = (event_kind == KIND_CORRECT) || (event_priority == PRIO_TAIL) ||
                       (event_priority == PRIO_ERROR);
    c_in.ent.trace   = trace_ident;
    c_in.ent.span    = span_ident;
    c_in.ent.time_ns = time_ns;
    c_in.ent.measure = measure;
  end

  assign full      = cnt[1];
  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= c_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("front queue count out of range");
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> full)
    else $error("front queue lost a word");
  a_empty_nopop: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid && !do_push |=> !cmd_valid)
    else $error("front queue invented a word");

endmodule

// ===== src/prbs_outq.sv =====
// ----------------------------------------------------------------------------
// prbs_outq
// Two-entry result queue towards the consumer.
// ----------------------------------------------------------------------------
module prbs_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  output logic              res_full,
  input  prbs_pkg::result_t res_in,
  output logic              empty,
  input  logic              pop,
  output prbs_pkg::result_t res_out
);
  import prbs_pkg::*;

  result_t    q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign res_full = cnt[1];
  assign empty    = cnt == 2'd0;
  assign res_out  = q[rp];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");
  a_keep: assert property (@(posedge clk) disable iff (rst)
    !empty && !do_pop |=> !empty)
    else $error("result queue lost a word");
  a_none: assert property (@(posedge clk) disable iff (rst)
    empty && !do_push |=> empty)
    else $error("result queue invented a word");

endmodule

// ===== src/prbs_back.sv =====
// ----------------------------------------------------------------------------
// prbs_back
// Store, eviction sequencer, drop counters and sampling rate control.
// ----------------------------------------------------------------------------
module prbs_back #(
  parameter int unsigned STORE_DEPTH  = 64,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [prbs_pkg::IDX_W-1:0]    cfg_addr,
  input  logic [prbs_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  prbs_pkg::cmd_t                cmd,
  output logic                          res_push,
  input  logic                          res_full,
  output prbs_pkg::result_t             res
);
  import prbs_pkg::*;

  localparam int unsigned AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int unsigned PW     = CW + 11;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_SHIFT = 10'b0000001000,
    S_SHWR  = 10'b0000010000,
    S_RMUL  = 10'b0000100000,
    S_RCMP  = 10'b0001000000,
    S_REC   = 10'b0010000000,
    S_EXRD  = 10'b0100000000,
    S_EXOUT = 10'b1000000000
  } state_t;

  state_t state;

  logic [CAP_W-1:0] capacity;
  logic [CFG_W-1:0] base_rate, floor_rate, low_mark, high_mark;
  logic [9:0]       rate_now;

  logic [COUNTER_BITS-1:0] verbose_count, normal_count, critical_count;
  logic [FILL_W-1:0]       fill, idx, n_exp;
  cmd_t                    cur;
  status_t                 st;
  logic [PW-1:0]           p_fill, p_hi, p_lo;

  entry_t          mem [STORE_DEPTH];
  entry_t          rd_data;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   eff_cap;
  logic [9:0]      eff_base, eff_floor, floor_clip;
  logic [FILL_W-1:0] idx_inc;
  logic            evictable;
  logic [63:0]     v64, n64, c64;

  always_comb begin
    if (capacity == '0) eff_cap = CW'(1);
    else if (CW'(capacity) > CW'(STORE_DEPTH)) eff_cap = CW'(STORE_DEPTH);
    else eff_cap = CW'(capacity);
    eff_base   = (base_rate > 10'(PER_MILLE)) ? 10'(PER_MILLE) : base_rate;
    floor_clip = (floor_rate > 10'(PER_MILLE)) ? 10'(PER_MILLE) : floor_rate;
    eff_floor  = (floor_clip > eff_base) ? eff_base : floor_clip;
  end

  assign idx_inc   = idx + FILL_W'(1);
  assign evictable = (rd_data.kind == KIND_SPAN) &&
                     ((rd_data.prio == PRIO_VERBOSE) || (rd_data.prio == PRIO_NORMAL));
  assign rd_addr   = (state == S_SHIFT) ? idx_inc[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = cur.ent;
    cmd_pop = (state == S_IDLE) && cmd_valid;
    if (state == S_IDLE && cmd_valid && cmd.mode == MODE_RECORD &&
        CW'(fill) < eff_cap) begin
      wr_en   = 1'b1;
      wr_data = cmd.ent;
    end else if (state == S_SHIFT) begin
      wr_en   = idx_inc >= fill;
      wr_addr = idx[AW-1:0];
    end else if (state == S_SHWR) begin
      wr_en   = 1'b1;
      wr_addr = idx[AW-1:0];
      wr_data = rd_data;
    end
  end

  always_comb begin
    v64 = 64'(verbose_count);
    n64 = 64'(normal_count);
    c64 = 64'(critical_count);
    res.status   = st;
    res.ent      = '0;
    res.last     = 1'b1;
    res.rate     = rate_now;
    res.verbose  = v64[31:0];
    res.normal   = n64[31:0];
    res.critical = c64[31:0];
    res_push     = 1'b0;
    if (state == S_REC) begin
      res_push = 1'b1;
    end else if (state == S_EXOUT) begin
      res_push   = 1'b1;
      res.status = ST_EXP_ENTRY;
      res.ent    = rd_data;
      res.last   = idx_inc == n_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) cur <= cmd;
    if (state == S_RMUL) begin
      p_fill <= PW'(fill) * PW'(PER_MILLE);
      p_hi   <= PW'(high_mark) * PW'(eff_cap);
      p_lo   <= (PW'(low_mark) + PW'(1)) * PW'(eff_cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity       <= CAP_W'(64);
      base_rate      <= CFG_W'(1000);
      floor_rate     <= CFG_W'(100);
      low_mark       <= CFG_W'(500);
      high_mark      <= CFG_W'(900);
      rate_now       <= 10'(PER_MILLE);
      verbose_count  <= '0;
      normal_count   <= '0;
      critical_count <= '0;
      fill           <= '0;
      idx            <= '0;
      n_exp          <= '0;
      st             <= ST_STORED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CAPACITY: capacity   <= cfg_data[CAP_W-1:0];
          REG_BASE:     base_rate  <= cfg_data;
          REG_FLOOR:    floor_rate <= cfg_data;
          REG_LOW:      low_mark   <= cfg_data;
          REG_HIGH:     high_mark  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.mode == MODE_RECORD) begin
              if (CW'(fill) < eff_cap) begin
                fill  <= fill + FILL_W'(1);
                st    <= ST_STORED;
                state <= S_RMUL;
              end else if (cmd.critical && fill != '0) begin
                idx   <= '0;
                state <= S_SCAN;
              end else if (cmd.critical) begin
                if (critical_count != '1) critical_count <= critical_count + 1'b1;
                st    <= ST_DROP_CRIT;
                state <= S_RMUL;
              end else begin
                if (cmd.ent.prio == PRIO_VERBOSE) begin
                  if (verbose_count != '1) verbose_count <= verbose_count + 1'b1;
                end else begin
                  if (normal_count != '1) normal_count <= normal_count + 1'b1;
                end
                st    <= ST_DROP_NC;
                state <= S_RMUL;
              end
            end else begin
              n_exp <= fill;
              idx   <= '0;
              st    <= ST_EXP_EMPTY;
              if (cmd.clear) begin
                fill  <= '0;
                state <= S_RMUL;
              end else if (fill == '0) begin
                state <= S_REC;
              end else begin
                state <= S_EXRD;
              end
            end
          end
        end
        S_SCAN: state <= S_CHECK;
        S_CHECK: begin
          if (evictable) begin
            if (rd_data.prio == PRIO_VERBOSE) begin
              if (verbose_count != '1) verbose_count <= verbose_count + 1'b1;
            end else begin
              if (normal_count != '1) normal_count <= normal_count + 1'b1;
            end
            state <= S_SHIFT;
          end else if (idx_inc >= fill) begin
            if (critical_count != '1) critical_count <= critical_count + 1'b1;
            st    <= ST_DROP_CRIT;
            state <= S_RMUL;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end
        S_SHIFT: begin
          if (idx_inc >= fill) begin
            st    <= ST_EVICTED;
            state <= S_RMUL;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx   <= idx_inc;
          state <= S_SHIFT;
        end
        S_RMUL: state <= S_RCMP;
        S_RCMP: begin
          if (p_fill >= p_hi) rate_now <= eff_floor;
          else if (p_fill < p_lo) rate_now <= eff_base;
          if (cur.mode == MODE_EXPORT && n_exp != '0) state <= S_EXRD;
          else state <= S_REC;
        end
        S_REC: begin
          if (!res_full) state <= S_IDLE;
        end
        S_EXRD: state <= S_EXOUT;
        S_EXOUT: begin
          if (!res_full) begin
            if (idx_inc == n_exp) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_EXRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");
  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT || state == S_SHWR || state == S_CHECK) |-> idx < fill)
    else $error("store walk beyond fill");
  a_push_state: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (state == S_REC || state == S_EXOUT))
    else $error("result pushed outside emit");
  a_fill_steady: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT || state == S_SHWR) |=> $stable(fill))
    else $error("fill changed during eviction");

endmodule

// ===== src/priority_retention_buffer_sampler.sv =====
// ----------------------------------------------------------------------------
// priority_retention_buffer_sampler
// Ordered bounded telemetry store with priority eviction and rate hysteresis.
// ----------------------------------------------------------------------------
// Record with room: front queue, S_IDLE, S_RMUL, S_RCMP, S_REC, result queue.
// Eviction: scan S_SCAN, S_CHECK; shift S_SHIFT, S_SHWR per entry; one store port.
// Export: S_EXRD and S_EXOUT per entry read out; a clear adds S_RMUL and S_RCMP.
// Words are handled one at a time by the back sequencer; queues of two decouple.
// Reset is synchronous: empty store, zero counters, rate 1000, default registers.
// No clearing pass; store contents are only read below the fill count.
module priority_retention_buffer_sampler #(
  parameter int unsigned STORE_DEPTH  = 64,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [prbs_pkg::IDX_W-1:0] cfg_addr,
  input  logic [prbs_pkg::CFG_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic                       mode,
  input  logic                       event_kind,
  input  logic [1:0]                 event_priority,
  input  logic [63:0]                trace_ident,
  input  logic [63:0]                span_ident,
  input  logic [63:0]                time_ns,
  input  logic [63:0]                measure,
  input  logic                       clear_after,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 status,
  output logic                       out_kind,
  output logic [1:0]                 out_priority,
  output logic [63:0]                out_trace,
  output logic [63:0]                out_span,
  output logic [63:0]                out_time,
  output logic [63:0]                out_measure,
  output logic                       last_item,
  output logic [9:0]                 sample_rate,
  output logic [31:0]                verbose_drops,
  output logic [31:0]                normal_drops,
  output logic [31:0]                critical_drops
);
  import prbs_pkg::*;

  logic    cmd_valid, cmd_pop, res_push, res_full;
  cmd_t    cmd;
  result_t res_in, res_out;

  prbs_front u_front (
    .clk, .rst, .push, .full, .mode, .event_kind, .event_priority,
    .trace_ident, .span_ident, .time_ns, .measure, .clear_after,
    .cmd_valid, .cmd_pop, .cmd
  );

  prbs_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .cmd_valid, .cmd_pop, .cmd,
    .res_push, .res_full, .res(res_in)
  );

  prbs_outq u_outq (
    .clk, .rst, .res_push, .res_full, .res_in,
    .empty, .pop, .res_out
  );

  assign status         = res_out.status;
  assign out_kind       = res_out.ent.kind;
  assign out_priority   = res_out.ent.prio;
  assign out_trace      = res_out.ent.trace;
  assign out_span       = res_out.ent.span;
  assign out_time       = res_out.ent.time_ns;
  assign out_measure    = res_out.ent.measure;
  assign last_item      = res_out.last;
  assign sample_rate    = res_out.rate;
  assign verbose_drops  = res_out.verbose;
  assign normal_drops   = res_out.normal;
  assign critical_drops = res_out.critical;

endmodule
